@@ src/wfg_pkg.sv @@
// Shared codes and control types of the wait-for graph deadlock detector.
`default_nettype none
package wfg_pkg;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_UNLOCK  = 2'd2;
  localparam logic [1:0] CMD_CHECK   = 2'd3;

  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_NO_DEADLOCK = 3'd1;
  localparam logic [2:0] ST_CYCLE       = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_UNKNOWN     = 3'd4;

  localparam int unsigned MaxResults = 17;
  localparam int unsigned KW         = 5;
  localparam int unsigned WW         = 5;
  localparam logic [WW-1:0] WaitMax  = 5'd31;

  typedef struct packed {
    logic accept;
    logic lscan;
    logic vscan;
    logic exec;
    logic root;
    logic dfs;
    logic findp;
    logic outc;
  } wfg_ctrl_t;

  typedef struct packed {
    logic is_check;
    logic lscan_end;
    logic vscan_end;
    logic out_free;
    logic root_end;
    logic root_skip;
    logic dfs_leaf;
    logic dfs_top0;
    logic dfs_hit;
    logic findp_end;
    logic outc_last;
  } wfg_stat_t;

endpackage
`default_nettype wire

@@ src/wfg_in_if.sv @@
// Input channel carrying command words.
`default_nettype none
interface wfg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] thread_id;
  logic [63:0] lock_address;
  modport source (output valid, command, thread_id, lock_address, input ready);
  modport sink (input valid, command, thread_id, lock_address, output ready);
endinterface
`default_nettype wire

@@ src/wfg_out_if.sv @@
// Output channel carrying result words.
`default_nettype none
interface wfg_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] cycle_thread;
  logic        last;
  modport source (output valid, status, cycle_thread, last, input ready);
  modport sink (input valid, status, cycle_thread, last, output ready);
endinterface
`default_nettype wire

@@ src/wfg_ctrl.sv @@
// Sequencing state machine of the deadlock detector.
`default_nettype none
module wfg_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wfg_pkg::wfg_stat_t  stat_i,
  output wfg_pkg::wfg_ctrl_t  ctrl_o
);
  import wfg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LSCAN = 3'd1;
  localparam logic [2:0] S_VSCAN = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_DFS   = 3'd5;
  localparam logic [2:0] S_FINDP = 3'd6;
  localparam logic [2:0] S_OUTC  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d = stat_i.is_check ? S_ROOT : S_LSCAN;
        end
      end
      S_LSCAN: begin
        ctrl_o.lscan = 1'b1;
        if (stat_i.lscan_end) state_d = S_VSCAN;
      end
      S_VSCAN: begin
        ctrl_o.vscan = 1'b1;
        if (stat_i.vscan_end) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          ctrl_o.exec = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ROOT: begin
        if (stat_i.root_end) begin
          if (stat_i.out_free) begin
            ctrl_o.root = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          ctrl_o.root = 1'b1;
          if (!stat_i.root_skip) state_d = S_DFS;
        end
      end
      S_DFS: begin
        ctrl_o.dfs = 1'b1;
        if (stat_i.dfs_leaf && stat_i.dfs_top0) state_d = S_ROOT;
        else if (stat_i.dfs_hit) state_d = S_FINDP;
      end
      S_FINDP: begin
        ctrl_o.findp = 1'b1;
        if (stat_i.findp_end) state_d = S_OUTC;
      end
      S_OUTC: begin
        if (stat_i.out_free) begin
          ctrl_o.outc = 1'b1;
          if (stat_i.outc_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/wfg_dp.sv @@
// Tables, wait-for matrix, search stack and output register of the detector.
`default_nettype none
module wfg_dp #(
  parameter int unsigned MAX_THREADS = 16,
  parameter int unsigned MAX_LOCKS   = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire [1:0]           command_i,
  input  wire [63:0]          thread_id_i,
  input  wire [63:0]          lock_address_i,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output logic [2:0]          status_o,
  output logic [63:0]         cycle_thread_o,
  output logic                last_o,
  input  wfg_pkg::wfg_ctrl_t  ctrl_i,
  output wfg_pkg::wfg_stat_t  stat_o
);
  import wfg_pkg::*;

  localparam int unsigned T  = MAX_THREADS;
  localparam int unsigned L  = MAX_LOCKS;
  localparam int unsigned IW = $clog2(T);
  localparam int unsigned CW = $clog2(T + 1);
  localparam int unsigned LW = (L > 1) ? $clog2(L) : 1;

  logic [63:0]   vid_q [T];
  logic [CW-1:0] vcnt_q;
  logic [T-1:0]  edge_q [T];
  logic [L-1:0]  lvalid_q;
  logic [63:0]   laddr_q [L];
  logic [63:0]   lown_q [L];
  logic [WW-1:0] wcnt_q [L];

  logic [IW-1:0] stk_q [T+1];
  logic [CW-1:0] nxt_q [T+1];
  logic [CW-1:0] top_q, r_q, p_q;
  logic [KW-1:0] k_q;
  logic [T-1:0]  on_q, done_q;
  logic [IW-1:0] hitv_q;

  logic [1:0]    cmd_q;
  logic [63:0]   tid_q, addr_q;
  logic [LW-1:0] lidx_q, lslot_q, lfree_q;
  logic          lhit_q, lfree_ok_q;
  logic [IW-1:0] vidx_q, fa_q, fb_q;
  logic          fa_ok_q, fb_ok_q;

  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [63:0]   out_thread_q;
  logic          out_last_q;

  logic [63:0]   owner;
  logic [IW-1:0] u, v;
  logic [T-1:0]  cand;
  logic          leaf;
  logic          self_req;
  logic [1:0]    need;
  logic [CW:0]   vsum;
  logic [IW-1:0] ia, ib;
  logic [CW-1:0] pend;
  logic          outc_last;

  assign owner    = lown_q[lslot_q];
  assign u        = stk_q[top_q];
  assign self_req = (tid_q == owner);

  always_comb begin
    cand = '0;
    for (int j = 0; j < T; j++) begin
      cand[j] = edge_q[u][j] && (CW'(j) >= nxt_q[top_q]) && (CW'(j) < vcnt_q);
    end
    v = '0;
    for (int j = T - 1; j >= 0; j--) begin
      if (cand[j]) v = IW'(j);
    end
    leaf = (cand == '0);
  end

  always_comb begin
    need = {1'b0, !fa_ok_q} + {1'b0, !fb_ok_q};
    if (self_req && need == 2'd2) need = 2'd1;
    vsum = {1'b0, vcnt_q} + (CW + 1)'(need);
    ia   = fa_ok_q ? fa_q : vcnt_q[IW-1:0];
    ib   = fb_ok_q ? fb_q : (self_req ? ia : IW'(vcnt_q + CW'(!fa_ok_q)));
  end

  assign outc_last = (p_q == top_q) || (k_q == KW'(MaxResults - 1));
  assign pend      = p_q;

  always_comb begin
    stat_o           = '0;
    stat_o.is_check  = (command_i == CMD_CHECK);
    stat_o.lscan_end = (lidx_q == LW'(L - 1));
    stat_o.vscan_end = (vidx_q == IW'(T - 1));
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.root_end  = (r_q >= vcnt_q);
    stat_o.root_skip = done_q[r_q[IW-1:0]];
    stat_o.dfs_leaf  = leaf;
    stat_o.dfs_top0  = (top_q == '0);
    stat_o.dfs_hit   = !leaf && on_q[v];
    stat_o.findp_end = !((p_q < top_q) && (stk_q[pend] != hitv_q));
    stat_o.outc_last = outc_last;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign cycle_thread_o = out_thread_q;
  assign last_o         = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= '0;
      lvalid_q    <= '0;
      on_q        <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < T; i++) begin
        vid_q[i]  <= '0;
        edge_q[i] <= '0;
      end
      for (int i = 0; i < L; i++) begin
        laddr_q[i] <= '0;
        lown_q[i]  <= '0;
        wcnt_q[i]  <= '0;
      end
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;

      if (ctrl_i.accept) begin
        cmd_q      <= command_i;
        tid_q      <= thread_id_i;
        addr_q     <= lock_address_i;
        lidx_q     <= '0;
        vidx_q     <= '0;
        lhit_q     <= 1'b0;
        lfree_ok_q <= 1'b0;
        fa_ok_q    <= 1'b0;
        fb_ok_q    <= 1'b0;
        on_q       <= '0;
        done_q     <= '0;
        r_q        <= '0;
      end

      if (ctrl_i.lscan) begin
        if (lvalid_q[lidx_q] && laddr_q[lidx_q] == addr_q && !lhit_q) begin
          lhit_q  <= 1'b1;
          lslot_q <= lidx_q;
        end
        if (!lvalid_q[lidx_q] && !lfree_ok_q) begin
          lfree_ok_q <= 1'b1;
          lfree_q    <= lidx_q;
        end
        lidx_q <= lidx_q + 1'b1;
      end

      if (ctrl_i.vscan) begin
        if (CW'(vidx_q) < vcnt_q) begin
          if (vid_q[vidx_q] == tid_q && !fa_ok_q) begin
            fa_ok_q <= 1'b1;
            fa_q    <= vidx_q;
          end
          if (lhit_q && vid_q[vidx_q] == owner && !fb_ok_q) begin
            fb_ok_q <= 1'b1;
            fb_q    <= vidx_q;
          end
        end
        vidx_q <= vidx_q + 1'b1;
      end

      if (ctrl_i.exec) begin
        out_valid_q  <= 1'b1;
        out_thread_q <= '0;
        out_last_q   <= 1'b1;
        out_status_q <= ST_DONE;
        unique case (cmd_q)
          CMD_REQUEST: begin
            if (lhit_q) begin
              if (vsum > (CW + 1)'(T)) begin
                out_status_q <= ST_FULL;
              end else begin
                if (!fa_ok_q) begin
                  vid_q[ia]  <= tid_q;
                  edge_q[ia] <= '0;
                end
                if (!fb_ok_q) begin
                  vid_q[ib]  <= owner;
                  edge_q[ib] <= '0;
                end
                vcnt_q <= vsum[CW-1:0];
                if (wcnt_q[lslot_q] < WaitMax) wcnt_q[lslot_q] <= wcnt_q[lslot_q] + 1'b1;
                edge_q[ia][ib] <= 1'b1;
              end
            end
          end
          CMD_ACQUIRE: begin
            if (!lhit_q) begin
              if (lfree_ok_q) begin
                lvalid_q[lfree_q] <= 1'b1;
                laddr_q[lfree_q]  <= addr_q;
                lown_q[lfree_q]   <= tid_q;
                wcnt_q[lfree_q]   <= '0;
              end else begin
                out_status_q <= ST_FULL;
              end
            end else begin
              if (wcnt_q[lslot_q] != '0) wcnt_q[lslot_q] <= wcnt_q[lslot_q] - 1'b1;
              if (fa_ok_q && fb_ok_q) edge_q[fa_q][fb_q] <= 1'b0;
              lown_q[lslot_q] <= tid_q;
            end
          end
          CMD_UNLOCK: begin
            if (!lhit_q) begin
              out_status_q <= ST_UNKNOWN;
            end else if (wcnt_q[lslot_q] == '0) begin
              lvalid_q[lslot_q] <= 1'b0;
              laddr_q[lslot_q]  <= '0;
              lown_q[lslot_q]   <= '0;
            end
          end
          default: out_status_q <= ST_DONE;
        endcase
      end

      if (ctrl_i.root) begin
        if (r_q >= vcnt_q) begin
          out_valid_q  <= 1'b1;
          out_status_q <= ST_NO_DEADLOCK;
          out_thread_q <= '0;
          out_last_q   <= 1'b1;
        end else if (done_q[r_q[IW-1:0]]) begin
          r_q <= r_q + 1'b1;
        end else begin
          top_q               <= '0;
          stk_q[0]            <= r_q[IW-1:0];
          nxt_q[0]            <= '0;
          on_q[r_q[IW-1:0]]   <= 1'b1;
        end
      end

      if (ctrl_i.dfs) begin
        if (leaf) begin
          on_q[u]   <= 1'b0;
          done_q[u] <= 1'b1;
          if (top_q == '0) r_q <= r_q + 1'b1;
          else top_q <= top_q - 1'b1;
        end else begin
          nxt_q[top_q] <= CW'(v) + 1'b1;
          if (on_q[v]) begin
            hitv_q <= v;
            p_q    <= '0;
          end else if (!done_q[v] && top_q < CW'(T)) begin
            top_q               <= top_q + 1'b1;
            stk_q[top_q + 1'b1] <= v;
            nxt_q[top_q + 1'b1] <= '0;
            on_q[v]             <= 1'b1;
          end
        end
      end

      if (ctrl_i.findp) begin
        if (!stat_o.findp_end) p_q <= p_q + 1'b1;
        else k_q <= '0;
      end

      if (ctrl_i.outc) begin
        out_valid_q  <= 1'b1;
        out_status_q <= ST_CYCLE;
        out_thread_q <= vid_q[stk_q[pend]];
        out_last_q   <= outc_last;
        p_q          <= p_q + 1'b1;
        k_q          <= k_q + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/wait_for_graph_deadlock_detector_top.sv @@
// Top level of the wait-for graph deadlock detector.
// Each word on the input channel is a lock request, lock acquisition, unlock or check.
// A lock command scans the lock table one slot a cycle and then the thread table one
// entry a cycle, and then loads its single result word once the output register is
// free. A check runs a depth-first search over the waits-for matrix, one edge step a
// cycle, and then delivers one result word per cycle while the output is not stalled,
// each cycle member in path order with the final word marked by last, or a single
// no-deadlock word when no cycle is found. One word is handled at a time; the next is
// taken once the previous result is placed in the output register.
`default_nettype none
module wait_for_graph_deadlock_detector_top #(
  parameter int unsigned MAX_THREADS = 16,
  parameter int unsigned MAX_LOCKS   = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  wfg_in_if.sink    in_i,
  wfg_out_if.source out_o
);
  import wfg_pkg::*;

  wfg_ctrl_t ctrl;
  wfg_stat_t stat;

  wfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wfg_dp #(
    .MAX_THREADS (MAX_THREADS),
    .MAX_LOCKS   (MAX_LOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (in_i.command),
    .thread_id_i    (in_i.thread_id),
    .lock_address_i (in_i.lock_address),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .cycle_thread_o (out_o.cycle_thread),
    .last_o         (out_o.last),
    .ctrl_i         (ctrl),
    .stat_o         (stat)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the wait-for graph deadlock detector.
`timescale 1ns / 1ps
module tb;
  import wfg_pkg::*;

  localparam int NT = 16;
  localparam int NL = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] cycle_thread;
    logic        last;
  } result_t;

  class detector_scoreboard;
    logic [63:0] thread_tab [NT];
    int          thread_cnt;
    logic [15:0] waits_on [NT];
    bit          slot_used [NL];
    logic [63:0] slot_addr [NL];
    logic [63:0] slot_owner [NL];
    int          slot_waiters [NL];
    result_t     pending [$];
    int          errors;

    function new();
      thread_cnt = 0;
      errors = 0;
      for (int i = 0; i < NT; i++) begin
        thread_tab[i] = '0;
        waits_on[i] = '0;
      end
      for (int i = 0; i < NL; i++) begin
        slot_used[i] = 0;
        slot_addr[i] = '0;
        slot_owner[i] = '0;
        slot_waiters[i] = 0;
      end
    endfunction

    function int thread_index(logic [63:0] id);
      for (int i = 0; i < thread_cnt; i++)
        if (thread_tab[i] == id) return i;
      return -1;
    endfunction

    function int slot_index(logic [63:0] addr);
      for (int i = 0; i < NL; i++)
        if (slot_used[i] && slot_addr[i] == addr) return i;
      return -1;
    endfunction

    function int add_thread(logic [63:0] id);
      int i;
      i = thread_index(id);
      if (i >= 0) return i;
      if (thread_cnt >= NT) return -1;
      thread_tab[thread_cnt] = id;
      waits_on[thread_cnt] = '0;
      thread_cnt++;
      return thread_cnt - 1;
    endfunction

    function void push(logic [2:0] st, logic [63:0] th, logic lst);
      result_t r;
      r.status = st;
      r.cycle_thread = th;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function logic [2:0] request(logic [63:0] tid, logic [63:0] addr);
      int s, a, b, need;
      s = slot_index(addr);
      if (s < 0) return ST_DONE;
      need = (thread_index(tid) < 0) + (thread_index(slot_owner[s]) < 0);
      if (tid == slot_owner[s] && need == 2) need = 1;
      if (thread_cnt + need > NT) return ST_FULL;
      a = add_thread(tid);
      b = add_thread(slot_owner[s]);
      if (a < 0 || b < 0) return ST_FULL;
      if (slot_waiters[s] < 31) slot_waiters[s]++;
      waits_on[a][b] = 1'b1;
      return ST_DONE;
    endfunction

    function logic [2:0] acquire(logic [63:0] tid, logic [63:0] addr);
      int s, a, b;
      s = slot_index(addr);
      if (s < 0) begin
        for (int i = 0; i < NL; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1;
            slot_addr[i] = addr;
            slot_owner[i] = tid;
            slot_waiters[i] = 0;
            return ST_DONE;
          end
        end
        return ST_FULL;
      end
      a = thread_index(tid);
      b = thread_index(slot_owner[s]);
      if (slot_waiters[s] > 0) slot_waiters[s]--;
      if (a >= 0 && b >= 0) waits_on[a][b] = 1'b0;
      slot_owner[s] = tid;
      return ST_DONE;
    endfunction

    function logic [2:0] unlock(logic [63:0] addr);
      int s;
      s = slot_index(addr);
      if (s < 0) return ST_UNKNOWN;
      if (slot_waiters[s] == 0) begin
        slot_used[s] = 0;
        slot_addr[s] = '0;
        slot_owner[s] = '0;
      end
      return ST_DONE;
    endfunction

    function void find_cycle();
      int path [NT+1];
      int nxt [NT+1];
      logic [15:0] on_path, finished;
      int n, top, u, v, p, k;
      n = thread_cnt;
      on_path = '0;
      finished = '0;
      for (int r = 0; r < n; r++) begin
        if (finished[r]) continue;
        top = 0;
        path[0] = r;
        nxt[0] = 0;
        on_path[r] = 1'b1;
        while (top >= 0) begin
          u = path[top];
          v = nxt[top];
          while (v < n && !waits_on[u][v]) v++;
          if (v >= n) begin
            on_path[u] = 1'b0;
            finished[u] = 1'b1;
            top--;
            continue;
          end
          nxt[top] = v + 1;
          if (on_path[v]) begin
            p = 0;
            k = 0;
            while (p < top && path[p] != v) p++;
            for (; p <= top && k < MaxResults; p++, k++)
              push(ST_CYCLE, thread_tab[path[p]], (p == top || k == MaxResults - 1));
            return;
          end
          if (!finished[v] && top < NT) begin
            top++;
            path[top] = v;
            nxt[top] = 0;
            on_path[v] = 1'b1;
          end
        end
      end
      push(ST_NO_DEADLOCK, '0, 1'b1);
    endfunction

    function void note_command(logic [1:0] cmd, logic [63:0] tid, logic [63:0] addr);
      case (cmd)
        CMD_REQUEST: push(request(tid, addr), '0, 1'b1);
        CMD_ACQUIRE: push(acquire(tid, addr), '0, 1'b1);
        CMD_UNLOCK:  push(unlock(addr), '0, 1'b1);
        default:     find_cycle();
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [63:0] th, logic lst);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word status=%0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (th !== e.cycle_thread) begin
        $error("cycle_thread: expected %h, got %h", e.cycle_thread, th);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  wfg_in_if  cmd_ch ();
  wfg_out_if res_ch ();

  wait_for_graph_deadlock_detector_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  detector_scoreboard sb;
  bit quiet;
  bit sending_done;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.status, res_ch.cycle_thread, res_ch.last);

  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] cmd, logic [63:0] tid, logic [63:0] addr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.thread_id <= tid;
    cmd_ch.lock_address <= addr;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(cmd, tid, addr);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_thread();
    if ($urandom_range(0, 9) == 0) return rand64() | 64'd1;
    return 64'd1 + $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] pick_lock();
    if ($urandom_range(0, 9) == 0) return rand64() | 64'd1;
    return 64'h1000 + $urandom_range(0, 9);
  endfunction

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic restart_tables();
    for (int i = 0; i < NL; i++)
      if (sb.slot_used[i]) begin
        while (sb.slot_waiters[i] > 0)
          send(CMD_ACQUIRE, sb.slot_owner[i], sb.slot_addr[i]);
        send(CMD_UNLOCK, 64'd0, sb.slot_addr[i]);
      end
  endtask

  initial begin
    logic [63:0] a, b;
    int r;
    sb = new();
    quiet = 0;
    rst_ni = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_CHECK;
    cmd_ch.thread_id = '0;
    cmd_ch.lock_address = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_CHECK, '0, '0);
    send(CMD_UNLOCK, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_REQUEST, 64'd5, 64'h55);
    send(CMD_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_CHECK, '0, '0);
    send(CMD_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_ACQUIRE, 64'd1, 64'd1);
    send(CMD_ACQUIRE, 64'd2, 64'd2);
    send(CMD_REQUEST, 64'd1, 64'd2);
    send(CMD_REQUEST, 64'd2, 64'd1);
    send(CMD_CHECK, '0, '0);
    send(CMD_UNLOCK, '0, 64'd1);
    send(CMD_ACQUIRE, 64'd2, 64'd1);
    send(CMD_ACQUIRE, 64'd1, 64'd2);
    send(CMD_CHECK, '0, '0);
    drain();

    for (int i = 0; i < 17; i++) send(CMD_ACQUIRE, 64'd100 + i, 64'h2000 + i);
    for (int i = 0; i < 16; i++) send(CMD_REQUEST, 64'd100 + i, 64'h2000 + (i + 1) % 16);
    send(CMD_REQUEST, 64'd999, 64'h2000);
    send(CMD_CHECK, '0, '0);
    for (int i = 0; i < 33; i++) send(CMD_REQUEST, 64'd101, 64'h2003);
    drain();

    for (int n = 0; n < 210; n++) begin
      if (n == 170) begin
        drain();
        quiet = 1;
      end
      if (n % 60 == 59) begin
        restart_tables();
        send(CMD_CHECK, '0, '0);
      end
      r = $urandom_range(0, 9);
      a = pick_thread();
      b = pick_lock();
      if (r < 3) send(CMD_ACQUIRE, a, b);
      else if (r < 6) send(CMD_REQUEST, a, b);
      else if (r < 8) send(CMD_UNLOCK, rand64() & {64{r[0]}} | a, b);
      else send(CMD_CHECK, rand64(), rand64());
    end
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
